>>> sv/srts_pkg.sv
`timescale 1ns / 1ps

package srts_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_COUNT  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECTION_BASE = 8'd1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_UNSORTED = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  found_index;
    logic [31:0] found_start;
    logic [31:0] found_size;
  } result_t;

endpackage

>>> sv/srts_ram.sv
`timescale 1ns / 1ps

module srts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = srts_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/srts_search.sv
`timescale 1ns / 1ps

module srts_search #(
  parameter int TABLE_DEPTH = srts_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [9:0]                     entry_index,
  input  logic [31:0]                    entry_start,
  input  logic [31:0]                    entry_size,
  input  logic [63:0]                    lookup_address,
  input  logic [10:0]                    table_count,
  input  logic [63:0]                    section_base,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output logic [63:0]                    ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  logic [63:0]                    ram_rdata,
  output logic                           res_valid,
  output srts_pkg::result_t              res,
  input  logic                           res_ready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_GAP    = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  function automatic logic [CNT_W-1:0] mid_of(input logic [CNT_W-1:0] l,
                                              input logic [CNT_W-1:0] h);
    return l + ((h - l - CNT_W'(1)) >> 1);
  endfunction

  state_t            state, state_next;
  logic [31:0]       off, off_next;
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  hix, hix_next;
  logic [31:0]       lowb, lowb_next;
  logic [31:0]       highb, highb_next;
  logic [IDX_W-1:0]  hit, hit_next;
  logic              hit_valid, hit_valid_next;
  logic [IDX_W-1:0]  mid_q, mid_q_next;
  srts_pkg::result_t res_q, res_next;

  logic              accept;
  logic [CNT_W-1:0]  n_sat;
  logic [31:0]       eidx_w;
  logic [31:0]       hit_w;
  logic [CNT_W-1:0]  probe;
  logic [31:0]       v_start;
  logic [31:0]       v_size;
  logic [32:0]       v_end;
  logic              unsorted;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_RESP);
  assign res       = res_q;
  assign v_start   = ram_rdata[63:32];
  assign v_size    = ram_rdata[31:0];
  assign v_end     = {1'b0, v_start} + {1'b0, v_size};
  assign eidx_w    = 32'(entry_index);
  assign hit_w     = 32'(hit);

  assign n_sat = (32'(table_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(table_count);

  assign ram_we    = accept && (command == srts_pkg::CMD_WRITE) &&
                     (eidx_w < 32'(TABLE_DEPTH));
  assign ram_waddr = eidx_w[IDX_W-1:0];
  assign ram_wdata = {entry_start, entry_size};

  always_comb begin
    state_next     = state;
    off_next       = off;
    lo_next        = lo;
    hix_next       = hix;
    lowb_next      = lowb;
    highb_next     = highb;
    hit_next       = hit;
    hit_valid_next = hit_valid;
    mid_q_next     = mid_q;
    res_next       = res_q;
    ram_re         = 1'b0;
    ram_raddr      = mid_q;
    probe          = '0;
    unsorted       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == srts_pkg::CMD_WRITE) begin
            res_next   = '{srts_pkg::ST_OK, 10'd0, 32'd0, 32'd0};
            state_next = S_RESP;
          end else begin
            off_next       = lookup_address[31:0] - section_base[31:0];
            lo_next        = '0;
            hix_next       = n_sat;
            lowb_next      = '0;
            highb_next     = '1;
            hit_valid_next = 1'b0;
            if (n_sat == '0) begin
              res_next   = '{srts_pkg::ST_MISS, 10'd0, 32'd0, 32'd0};
              state_next = S_RESP;
            end else begin
              probe      = mid_of('0, n_sat);
              ram_re     = 1'b1;
              ram_raddr  = probe[IDX_W-1:0];
              mid_q_next = probe[IDX_W-1:0];
              state_next = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        if (off >= v_start) begin
          unsorted       = (v_start < lowb);
          lowb_next      = v_start;
          hit_next       = mid_q;
          hit_valid_next = 1'b1;
          lo_next        = CNT_W'(mid_q) + CNT_W'(1);
        end else begin
          unsorted   = (v_start > highb);
          highb_next = v_start;
          hix_next   = CNT_W'(mid_q);
        end
        if (unsorted) begin
          res_next   = '{srts_pkg::ST_UNSORTED, 10'd0, 32'd0, 32'd0};
          state_next = S_RESP;
        end else if (lo_next < hix_next) begin
          probe      = mid_of(lo_next, hix_next);
          ram_re     = 1'b1;
          ram_raddr  = probe[IDX_W-1:0];
          mid_q_next = probe[IDX_W-1:0];
        end else if (hit_valid_next) begin
          ram_re     = 1'b1;
          ram_raddr  = hit_next;
          state_next = S_GAP;
        end else begin
          res_next   = '{srts_pkg::ST_MISS, 10'd0, 32'd0, 32'd0};
          state_next = S_RESP;
        end
      end
      S_GAP: begin
        if ((off < v_start) || ({1'b0, off} >= v_end)) begin
          res_next = '{srts_pkg::ST_MISS, 10'd0, 32'd0, 32'd0};
        end else begin
          res_next = '{srts_pkg::ST_OK, hit_w[9:0], v_start, v_size};
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hit_valid <= 1'b0;
    end else begin
      state     <= state_next;
      hit_valid <= hit_valid_next;
    end
    off   <= off_next;
    lo    <= lo_next;
    hix   <= hix_next;
    lowb  <= lowb_next;
    highb <= highb_next;
    hit   <= hit_next;
    mid_q <= mid_q_next;
    res_q <= res_next;
  end

`ifndef NO_ASSERTIONS
  a_window_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (lo < hix))
    else $error("search window empty while probing");

  a_lowb_below_off: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SEARCH) && hit_valid) |-> (lowb <= off))
    else $error("low bound above offset");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE))
    else $error("table write outside idle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status != srts_pkg::ST_OK)) |->
      ((res.found_index == 10'd0) && (res.found_start == 32'd0) &&
       (res.found_size == 32'd0)))
    else $error("nonzero payload on miss");

  a_gap_after_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_GAP) |-> hit_valid)
    else $error("gap check without hit");
`endif

endmodule

>>> sv/sorted_range_table_search.sv
`timescale 1ns / 1ps
// write word: the result goes through S_RESP into the output register; out_valid rises once that register is free
// lookup word: p probes in S_SEARCH, a gap check in S_GAP only after a hit, then S_RESP and the output register,
// p = binary search probes (at most floor(log2(table_count)) + 1)
// one table read per cycle through the registered ram port sets the probe rate
// one word at a time: in_ready returns once the result enters the output register
// rst clears control state and both config registers; table contents undefined until written
module sorted_range_table_search #(
  parameter int TABLE_DEPTH = srts_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [9:0]                       entry_index,
  input  logic [31:0]                      entry_start,
  input  logic [31:0]                      entry_size,
  input  logic [63:0]                      lookup_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic [9:0]                       found_index,
  output logic [31:0]                      found_start,
  output logic [31:0]                      found_size,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [srts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [10:0]       table_count;
  logic [63:0]       section_base;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [63:0]       ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [63:0]       ram_rdata;
  logic              res_valid;
  logic              res_ready;
  srts_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count  <= '0;
      section_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srts_pkg::CFG_TABLE_COUNT:  table_count  <= cfg_data[10:0];
        srts_pkg::CFG_SECTION_BASE: section_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      status      <= res.status;
      found_index <= res.found_index;
      found_start <= res.found_start;
      found_size  <= res.found_size;
    end
  end

  srts_ram #(
    .WIDTH(64),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  srts_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_search (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .entry_index   (entry_index),
    .entry_start   (entry_start),
    .entry_size    (entry_size),
    .lookup_address(lookup_address),
    .table_count   (table_count),
    .section_base  (section_base),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready)
  );

endmodule
